FILE: src/tsfg_pkg.sv
// Shared types, constants and helper functions for the tetrahedron
// shape-function gradient block. No dependencies; every other file but tsfg_ram imports it.
package tsfg_pkg;

  // Field and datapath widths.
  localparam int COORD_W     = 32;
  localparam int FIELD_W     = 32;
  localparam int VOL_W       = 31;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_W       = 32;
  localparam int NODE_W      = 2;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 128;
  localparam int VTX_W       = 3 * COORD_W;
  localparam int VTX_DEPTH   = 4;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int CROSS_W     = 2 * DIFF_W + 1;
  localparam int CLO_W       = 33;
  localparam int OPND_W      = 35;
  localparam int PROD_W      = 2 * OPND_W;
  localparam int ACC_W       = 130;
  localparam int SHIFT_W     = 6;

  // Reciprocal of six times the volume, scaled by 2^RECIP_SHIFT.
  localparam int RECIP_SHIFT = 62;
  localparam int RECIP_W     = 60;
  localparam int RHALF       = RECIP_W / 2;
  localparam int DIV_W       = VOL_W + 3;
  localparam int NUM_W       = RECIP_SHIFT + 1;

  // Rounding offsets, half an LSB of the result.
  localparam logic signed [ACC_W-1:0] RND_G = ACC_W'(1) << (RECIP_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] RND_P = ACC_W'(1) << (FRAC_BITS - 1);

  // Sequencer step layout for one node.
  localparam int STEP_W     = 6;
  localparam int PRO_STEPS  = 5;
  localparam int GRAD_STEPS = 10;
  localparam int PLANE_BASE = PRO_STEPS + 3 * GRAD_STEPS;

  // Vertex indices per node: edge ends A and B and the reference vertex R.
  localparam logic [1:0] NODE_A [VTX_DEPTH] = '{2'd3, 2'd3, 2'd1, 2'd1};
  localparam logic [1:0] NODE_B [VTX_DEPTH] = '{2'd2, 2'd0, 2'd0, 2'd2};
  localparam logic [1:0] NODE_R [VTX_DEPTH] = '{2'd1, 2'd2, 2'd3, 2'd0};

  // Operand sources of the shared multiplier.
  typedef enum logic [3:0] {
    SEL_DA0, SEL_DA1, SEL_DA2, SEL_DB0, SEL_DB1, SEL_DB2,
    SEL_CLO, SEL_CHI, SEL_RLO, SEL_RHI,
    SEL_G0, SEL_G1, SEL_G2, SEL_R0, SEL_R1, SEL_R2
  } opsel_t;

  typedef enum logic [3:0] {
    UOP_RDA, UOP_RDB, UOP_RDR, UOP_CAPR, UOP_DIFF, UOP_MUL,
    UOP_NOP, UOP_LATCHC, UOP_RNDG, UOP_RNDP, UOP_EMIT
  } uop_kind_t;

  typedef struct packed {
    uop_kind_t            kind;
    opsel_t               asel;
    opsel_t               bsel;
    logic                 first;
    logic                 neg;
    logic [SHIFT_W-1:0]   shift;
    logic [1:0]           gidx;
  } uop_t;

  // Control of the multiply-accumulate unit.
  typedef struct packed {
    logic               valid;
    logic               first;
    logic               neg;
    logic [SHIFT_W-1:0] shift;
  } mac_ctl_t;

  // Decode of one sequencer step within a node.
  function automatic uop_t tsfg_uop(input logic [STEP_W-1:0] step);
    uop_t              u;
    logic [STEP_W-1:0] t;
    logic [STEP_W-1:0] t2;
    logic [1:0]        j;
    logic [3:0]        sub;
    logic [1:0]        i1;
    logic [1:0]        i2;
    u = '{kind: UOP_NOP, asel: SEL_DA0, bsel: SEL_DA0, first: 1'b0, neg: 1'b0,
          shift: '0, gidx: 2'd0};
    t  = step - STEP_W'(PRO_STEPS);
    t2 = step - STEP_W'(PLANE_BASE);
    if (t < STEP_W'(GRAD_STEPS)) begin
      j   = 2'd0;
      sub = t[3:0];
    end else if (t < STEP_W'(2 * GRAD_STEPS)) begin
      j   = 2'd1;
      sub = 4'(t - STEP_W'(GRAD_STEPS));
    end else begin
      j   = 2'd2;
      sub = 4'(t - STEP_W'(2 * GRAD_STEPS));
    end
    i1 = (j == 2'd2) ? 2'd0 : j + 2'd1;
    i2 = (j == 2'd0) ? 2'd2 : j - 2'd1;
    if (step < STEP_W'(PRO_STEPS)) begin
      case (step[2:0])
        3'd0:    u.kind = UOP_RDA;
        3'd1:    u.kind = UOP_RDB;
        3'd2:    u.kind = UOP_RDR;
        3'd3:    u.kind = UOP_CAPR;
        default: u.kind = UOP_DIFF;
      endcase
    end else if (step < STEP_W'(PLANE_BASE)) begin
      u.gidx = j;
      case (sub)
        4'd0: begin
          u.kind  = UOP_MUL;
          u.asel  = opsel_t'(4'(SEL_DA0) + 4'(i1));
          u.bsel  = opsel_t'(4'(SEL_DB0) + 4'(i2));
          u.first = 1'b1;
        end
        4'd1: begin
          u.kind = UOP_MUL;
          u.asel = opsel_t'(4'(SEL_DB0) + 4'(i1));
          u.bsel = opsel_t'(4'(SEL_DA0) + 4'(i2));
          u.neg  = 1'b1;
        end
        4'd3: u.kind = UOP_LATCHC;
        4'd4: begin
          u.kind  = UOP_MUL;
          u.asel  = SEL_CLO;
          u.bsel  = SEL_RLO;
          u.first = 1'b1;
        end
        4'd5: begin
          u.kind  = UOP_MUL;
          u.asel  = SEL_CLO;
          u.bsel  = SEL_RHI;
          u.shift = SHIFT_W'(RHALF);
        end
        4'd6: begin
          u.kind  = UOP_MUL;
          u.asel  = SEL_CHI;
          u.bsel  = SEL_RLO;
          u.shift = SHIFT_W'(CLO_W);
        end
        4'd7: begin
          u.kind  = UOP_MUL;
          u.asel  = SEL_CHI;
          u.bsel  = SEL_RHI;
          u.shift = SHIFT_W'(CLO_W + RHALF);
        end
        4'd9:    u.kind = UOP_RNDG;
        default: u.kind = UOP_NOP;
      endcase
    end else begin
      case (t2[2:0])
        3'd0, 3'd1, 3'd2: begin
          u.kind  = UOP_MUL;
          u.asel  = opsel_t'(4'(SEL_G0) + 4'(t2));
          u.bsel  = opsel_t'(4'(SEL_R0) + 4'(t2));
          u.first = (t2[2:0] == 3'd0);
        end
        3'd3:    u.kind = UOP_NOP;
        3'd4:    u.kind = UOP_RNDP;
        default: u.kind = UOP_EMIT;
      endcase
    end
    return u;
  endfunction

  // Clamp a wide signed value to the output range.
  function automatic logic [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic fits;
    fits = (&v[ACC_W-1:OUT_W-1]) | ~(|v[ACC_W-1:OUT_W-1]);
    if (fits) begin
      return v[OUT_W-1:0];
    end
    return v[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
  endfunction

  // Difference of one coordinate of two packed vertices, one bit wider.
  function automatic logic signed [DIFF_W-1:0] coord_diff(input logic [VTX_W-1:0] p,
                                                          input logic [VTX_W-1:0] q,
                                                          input int i);
    logic [COORD_W-1:0] pc;
    logic [COORD_W-1:0] qc;
    pc = p[i*COORD_W +: COORD_W];
    qc = q[i*COORD_W +: COORD_W];
    return $signed({pc[COORD_W-1], pc}) - $signed({qc[COORD_W-1], qc});
  endfunction

endpackage

FILE: src/tetra_shape_function_gradients.sv
// Shape-function gradients of a linear tetrahedron, in signed Q16.16.
// Depends on tsfg_pkg, tsfg_ram, tsfg_div and tsfg_mac.
//
// Use: send the four vertices of an element on the in_ channel, one per
// request. The element volume is read only with the fourth vertex. The
// first three vertices are only stored. After the fourth, the block
// drops in_tready, runs a bit-serial reciprocal of six times the volume,
// then computes the four nodes one after another on a single
// shared 35x35 multiplier: 41 sequencer steps per node (read vertices,
// differences, two products per cross term, four partial products for the
// scaling, three for the plane offset). Results carry node_number in
// out_tuser and last_of_element in out_tlast. A stalled receiver holds the
// result in the output register; the sequencer waits at the end of the
// next node until it is taken. in_tready returns once the fourth result is
// in the output register. Synchronous reset clears the vertex count, the
// sequencer and out_tvalid.
module tetra_shape_function_gradients import tsfg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // vertex_x[31:0], vertex_y[63:32], vertex_z[95:64], element_volume[126:96]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // grad_x[31:0], grad_y[63:32], grad_z[95:64], plane_offset[127:96]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // node_number[1:0]
  output logic [NODE_W-1:0]      out_tuser,
  output logic                   out_tlast
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_NODE} state_t;

  state_t                   state_r;
  logic [1:0]               cnt_r;
  logic [NODE_W-1:0]        node_r;
  logic [STEP_W-1:0]        step_r;
  logic [VTX_W-1:0]         a_r;
  logic [VTX_W-1:0]         b_r;
  logic [VTX_W-1:0]         rv_r;
  logic signed [DIFF_W-1:0] da_r [3];
  logic signed [DIFF_W-1:0] db_r [3];
  logic [CROSS_W-1:0]       c_r;
  logic [OUT_W-1:0]         g_r [3];
  logic [OUT_W-1:0]         plane_r;
  logic                     out_tvalid_r;
  logic [OUT_TDATA_W-1:0]   out_tdata_r;
  logic [NODE_W-1:0]        out_tuser_r;
  logic                     out_tlast_r;

  logic                     in_acc;
  logic                     can_load;
  logic                     emit;
  uop_t                     uop;
  logic [VOL_W-1:0]         vol;
  logic [DIV_W-1:0]         vol_ext;
  logic [DIV_W-1:0]         divisor;
  logic                     div_start;
  logic                     div_done;
  logic [RECIP_W-1:0]       recip;
  logic [VTX_W-1:0]         wdata;
  logic [1:0]               raddr;
  logic [VTX_W-1:0]         rdata;
  logic signed [OPND_W-1:0] opnd [16];
  mac_ctl_t                 mac_ctl;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rnd_g;
  logic signed [ACC_W-1:0]  rnd_p;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign can_load  = !out_tvalid_r || out_tready;
  assign uop       = tsfg_uop(step_r);
  assign emit      = (state_r == ST_NODE) && (uop.kind == UOP_EMIT) && can_load;

  // Six times the volume, a zero volume counted as one LSB.
  always_comb begin
    vol       = in_tdata[3*FIELD_W +: VOL_W];
    vol_ext   = (vol == '0) ? DIV_W'(1) : DIV_W'(vol);
    divisor   = (vol_ext << 2) + (vol_ext << 1);
    div_start = in_acc && (cnt_r == 2'd3);
    wdata     = {in_tdata[2*FIELD_W +: COORD_W], in_tdata[FIELD_W +: COORD_W],
                 in_tdata[0 +: COORD_W]};
  end

  // Vertex address for the read steps of the current node.
  always_comb begin
    case (uop.kind)
      UOP_RDA: raddr = NODE_A[node_r];
      UOP_RDB: raddr = NODE_B[node_r];
      UOP_RDR: raddr = NODE_R[node_r];
      default: raddr = 2'd0;
    endcase
  end

  tsfg_ram #(
    .WIDTH(VTX_W),
    .DEPTH(VTX_DEPTH)
  ) u_vtx_ram (
    .clk  (clk),
    .we   (in_acc),
    .waddr(cnt_r),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  tsfg_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (divisor),
    .done    (div_done),
    .quotient(recip)
  );

  // Operand sources for the shared multiplier.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      opnd[int'(SEL_DA0) + i] = OPND_W'(da_r[i]);
      opnd[int'(SEL_DB0) + i] = OPND_W'(db_r[i]);
      opnd[int'(SEL_G0) + i]  = OPND_W'($signed(g_r[i]));
      opnd[int'(SEL_R0) + i]  = OPND_W'($signed(rv_r[i*COORD_W +: COORD_W]));
    end
    opnd[SEL_CLO] = $signed({{(OPND_W-CLO_W){1'b0}}, c_r[CLO_W-1:0]});
    opnd[SEL_CHI] = OPND_W'($signed(c_r[CROSS_W-1:CLO_W]));
    opnd[SEL_RLO] = $signed({{(OPND_W-RHALF){1'b0}}, recip[RHALF-1:0]});
    opnd[SEL_RHI] = $signed({{(OPND_W-RHALF){1'b0}}, recip[RECIP_W-1:RHALF]});
  end

  always_comb begin
    mac_ctl.valid = (state_r == ST_NODE) && (uop.kind == UOP_MUL);
    mac_ctl.first = uop.first;
    mac_ctl.neg   = uop.neg;
    mac_ctl.shift = uop.shift;
  end

  tsfg_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .opnd_a(opnd[uop.asel]),
    .opnd_b(opnd[uop.bsel]),
    .acc   (acc)
  );

  // Round half up, then drop the scaling bits.
  always_comb begin
    rnd_g = (acc + RND_G) >>> RECIP_SHIFT;
    rnd_p = (acc + RND_P) >>> FRAC_BITS;
  end

  // Sequencer, datapath registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      node_r       <= '0;
      step_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tready && !emit) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cnt_r <= cnt_r + 2'd1;
            if (cnt_r == 2'd3) begin
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_NODE;
            node_r  <= '0;
            step_r  <= '0;
          end
        end
        ST_NODE: begin
          case (uop.kind)
            UOP_RDB:    a_r  <= rdata;
            UOP_RDR:    b_r  <= rdata;
            UOP_CAPR:   rv_r <= rdata;
            UOP_DIFF: begin
              for (int i = 0; i < 3; i++) begin
                da_r[i] <= coord_diff(a_r, rv_r, i);
                db_r[i] <= coord_diff(b_r, rv_r, i);
              end
            end
            UOP_LATCHC: c_r           <= acc[CROSS_W-1:0];
            UOP_RNDG:   g_r[uop.gidx] <= sat_out(rnd_g);
            UOP_RNDP:   plane_r       <= sat_out(rnd_p);
            default: ;
          endcase
          if (uop.kind == UOP_EMIT) begin
            if (can_load) begin
              out_tvalid_r <= 1'b1;
              out_tdata_r  <= {plane_r, g_r[2], g_r[1], g_r[0]};
              out_tuser_r  <= node_r;
              out_tlast_r  <= (node_r == NODE_W'(3));
              step_r       <= '0;
              node_r       <= node_r + NODE_W'(1);
              if (node_r == NODE_W'(3)) begin
                state_r <= ST_IDLE;
              end
            end
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

FILE: src/tsfg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsfg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: src/tsfg_div.sv
// Bit-serial restoring divider that forms round(2^62 / d), one quotient bit
// per cycle. Depends on tsfg_pkg.
module tsfg_div import tsfg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_W-1:0]   divisor,
  output logic               done,
  output logic [RECIP_W-1:0] quotient
);

  logic               run_r;
  logic               done_r;
  logic [5:0]         cnt_r;
  logic [DIV_W-1:0]   d_r;
  logic [DIV_W-1:0]   rem_r;
  logic [NUM_W-1:0]   num_r;
  logic [RECIP_W-1:0] q_r;
  logic [DIV_W:0]     trial;
  logic [DIV_W:0]     trial_sub;
  logic               qbit;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    trial     = {rem_r, num_r[NUM_W-1]};
    trial_sub = trial - {1'b0, d_r};
    qbit      = (trial >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        d_r   <= divisor;
        rem_r <= '0;
        // Dividend is 2^62 plus half the divisor, for round to nearest.
        num_r <= (NUM_W'(1) << RECIP_SHIFT) + NUM_W'(divisor >> 1);
      end else if (run_r) begin
        rem_r <= qbit ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
        num_r <= num_r << 1;
        q_r   <= {q_r[RECIP_W-2:0], qbit};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(NUM_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: src/tsfg_mac.sv
// Shared multiply-accumulate unit: a registered signed multiply, then a
// shifted add or subtract into a wide accumulator. Depends on tsfg_pkg.
module tsfg_mac import tsfg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic signed [OPND_W-1:0] opnd_a,
  input  logic signed [OPND_W-1:0] opnd_b,
  output logic signed [ACC_W-1:0]  acc
);

  mac_ctl_t                  ctl_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   base;

  // Align the product and pick the accumulator base.
  always_comb begin
    term = $signed({{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r}) <<< ctl_r.shift;
    base = ctl_r.first ? '0 : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
    prod_r <= opnd_a * opnd_b;
    if (ctl_r.valid) begin
      acc_r <= ctl_r.neg ? base - term : base + term;
    end
  end

  assign acc = acc_r;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for tetra_shape_function_gradients.
// Depends on tsfg_pkg and the block's RTL; predicts the four node gradients per element.
`timescale 1ns / 1ps

module tb_top;
  import tsfg_pkg::*;

  typedef struct packed {
    logic [31:0] gx;
    logic [31:0] gy;
    logic [31:0] gz;
    logic [31:0] po;
    logic [1:0]  node;
    logic        last;
  } grad_res_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [30:0] vol;
    logic        has_exp;
    grad_res_t   exp0;
  } vtx_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [NODE_W-1:0]      out_tuser;
  logic                   out_tlast;

  tetra_shape_function_gradients dut (.*);

  // Predictor state: the first three vertices of the element.
  logic signed [31:0] kept_x [3];
  logic signed [31:0] kept_y [3];
  logic signed [31:0] kept_z [3];
  int                 kept_cnt;
  grad_res_t          expected_grads [$];
  int                 fail_cnt;
  bit                 no_idle;
  bit                 hold_rx;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] sat32(input logic signed [191:0] v);
    if (v > 192'sd2147483647) return 32'h7fffffff;
    if (v < -192'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Compute the four node results for the element closed by vertex p3.
  task automatic predict_element(input logic signed [31:0] px, input logic signed [31:0] py,
                                 input logic signed [31:0] pz, input logic [30:0] vol);
    logic signed [191:0] pt [4][3];
    logic signed [191:0] da [3];
    logic signed [191:0] db [3];
    logic signed [191:0] cr;
    logic signed [191:0] acc;
    logic [63:0]         d;
    logic [63:0]         rc;
    logic [31:0]         g [3];
    int                  ia;
    int                  ib;
    int                  ir;
    grad_res_t           r;
    for (int i = 0; i < 3; i++) begin
      pt[i][0] = kept_x[i];
      pt[i][1] = kept_y[i];
      pt[i][2] = kept_z[i];
    end
    pt[3][0] = px;
    pt[3][1] = py;
    pt[3][2] = pz;
    d = 64'd6 * ((vol == 0) ? 64'd1 : 64'(vol));
    rc = ((64'd1 << 62) + d / 2) / d;
    for (int k = 0; k < 4; k++) begin
      ia = NODE_A[k];
      ib = NODE_B[k];
      ir = NODE_R[k];
      for (int j = 0; j < 3; j++) begin
        da[j] = pt[ia][j] - pt[ir][j];
        db[j] = pt[ib][j] - pt[ir][j];
      end
      for (int j = 0; j < 3; j++) begin
        cr = da[(j + 1) % 3] * db[(j + 2) % 3] - db[(j + 1) % 3] * da[(j + 2) % 3];
        g[j] = sat32((cr * $signed({128'd0, rc}) + (192'sd1 <<< 61)) >>> 62);
      end
      acc = 0;
      for (int j = 0; j < 3; j++) acc += $signed(g[j]) * pt[ir][j];
      r.gx = g[0];
      r.gy = g[1];
      r.gz = g[2];
      r.po = sat32((acc + 192'sd32768) >>> 16);
      r.node = 2'(k);
      r.last = (k == 3);
      expected_grads.push_back(r);
    end
  endtask

  // Send one vertex request and update the predictor when it is taken.
  task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [30:0] vol);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, vol, z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kept_cnt < 3) begin
      kept_x[kept_cnt] = x;
      kept_y[kept_cnt] = y;
      kept_z[kept_cnt] = z;
      kept_cnt++;
    end else begin
      predict_element(x, y, z, vol);
      kept_cnt = 0;
    end
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_tready <= 1'b0;
        repeat (600) @(negedge clk);
        hold_rx = 1'b0;
      end
      if (!no_idle && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    grad_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_grads.size() == 0) begin
        $error("unexpected result node %0d", out_tuser);
        fail_cnt++;
      end else begin
        e = expected_grads.pop_front();
        if (out_tdata[31:0] !== e.gx) begin
          $error("grad_x exp %h got %h", e.gx, out_tdata[31:0]); fail_cnt++;
        end
        if (out_tdata[63:32] !== e.gy) begin
          $error("grad_y exp %h got %h", e.gy, out_tdata[63:32]); fail_cnt++;
        end
        if (out_tdata[95:64] !== e.gz) begin
          $error("grad_z exp %h got %h", e.gz, out_tdata[95:64]); fail_cnt++;
        end
        if (out_tdata[127:96] !== e.po) begin
          $error("plane_offset exp %h got %h", e.po, out_tdata[127:96]); fail_cnt++;
        end
        if (out_tuser !== e.node) begin
          $error("node_number exp %0d got %0d", e.node, out_tuser); fail_cnt++;
        end
        if (out_tlast !== e.last) begin
          $error("last_of_element exp %0d got %0d", e.last, out_tlast); fail_cnt++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2097152)) - 1048576) <<< 4;
    endcase
  endfunction

  // Stimulus: directed table, then random elements.
  initial begin
    vtx_row_t  rows [$];
    vtx_row_t  rw;
    grad_res_t e;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    rst_n     = 1'b0;
    kept_cnt  = 0;
    fail_cnt  = 0;
    no_idle   = 1'b0;
    hold_rx   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Degenerate element of all-zero vertices: every gradient and plane offset of every node is zero.
    e = '{gx: 0, gy: 0, gz: 0, po: 0, node: 0, last: 0};
    for (int i = 0; i < 4; i++) rows.push_back('{0, 0, 0, 31'd5, 1'b0, e});
    rows[3].has_exp = 1'b1;
    // Unit tetrahedron, volume 1/6, volume on early items ignored.
    rows.push_back('{32'h0, 32'h0, 32'h0, 31'h7fffffff, 1'b0, e});
    rows.push_back('{32'h10000, 32'h0, 32'h0, 31'd0, 1'b0, e});
    rows.push_back('{32'h0, 32'h10000, 32'h0, 31'd1, 1'b0, e});
    rows.push_back('{32'h0, 32'h0, 32'h10000, 31'h2aab, 1'b0, e});
    // Extreme coordinates with zero volume and with maximum volume.
    rows.push_back('{32'h7fffffff, 32'h80000000, 32'h0, 31'd0, 1'b0, e});
    rows.push_back('{32'h80000000, 32'h7fffffff, 32'hffffffff, 31'd0, 1'b0, e});
    rows.push_back('{32'h0, 32'h80000000, 32'h7fffffff, 31'd0, 1'b0, e});
    rows.push_back('{32'hffffffff, 32'h1, 32'h80000000, 31'd0, 1'b0, e});
    rows.push_back('{32'h80000000, 32'h80000000, 32'h80000000, 31'd9, 1'b0, e});
    rows.push_back('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'd9, 1'b0, e});
    rows.push_back('{32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f, 31'd9, 1'b0, e});
    rows.push_back('{32'hffffffff, 32'hffffffff, 32'hffffffff, 31'h7fffffff, 1'b0, e});

    foreach (rows[i]) begin
      rw = rows[i];
      send_vertex(rw.x, rw.y, rw.z, rw.vol);
      // The zero element's node 0 is known at a glance; pin it.
      if (rw.has_exp && expected_grads.size() > 0 && expected_grads[0] !== rw.exp0) begin
        $error("node0 table exp %h got %h", rw.exp0, expected_grads[0]);
        fail_cnt++;
      end
    end

    // Long receiver hold-off while elements keep arriving.
    hold_rx = 1'b1;
    for (int i = 0; i < 12; i++)
      send_vertex(rand_coord(), rand_coord(), rand_coord(), $urandom_range(1, 1000000));

    // Random elements; the last stretch runs without idling.
    for (int i = 0; i < 100; i++) begin
      if (i >= 80) no_idle = 1'b1;
      send_vertex(rand_coord(), rand_coord(), rand_coord(),
                  ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 65536)));
    end
    in_tvalid <= 1'b0;
    while (expected_grads.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_cnt == 0 && expected_grads.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
